### rtl/io_regs_pixel_and_flash_pointer_assert.svh
// Assertion macros shared by the pixel and flash pointer register block.
// No dependencies; define SYNTH to compile the checks out.
`ifndef IO_REGS_PIXEL_AND_FLASH_POINTER_ASSERT_SVH
`define IO_REGS_PIXEL_AND_FLASH_POINTER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside of reset.
`define IORPF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed: label");
// Check a property on every clock edge, reset included.
`define IORPF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("check failed: label");
`else
`define IORPF_ASSERT(label, clk, rst, prop)
`define IORPF_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/iorpf_pkg.sv
// Shared types and constants for the pixel and flash pointer register block.
// No dependencies.
package iorpf_pkg;

  localparam int PIXEL_SLOTS = 64;
  localparam int CURSOR_W    = $clog2(PIXEL_SLOTS);
  localparam int COUNT_W     = CURSOR_W + 1;
  localparam int PIXEL_W     = 24;
  localparam int PTR_W       = 20;

  localparam logic [7:0] REG_CTRL   = 8'h80;
  localparam logic [7:0] REG_RED    = 8'h82;
  localparam logic [7:0] REG_GREEN  = 8'h84;
  localparam logic [7:0] REG_BLUE   = 8'h86;
  localparam logic [7:0] REG_FDATA  = 8'h90;
  localparam logic [7:0] REG_FADDR0 = 8'h92;
  localparam logic [7:0] REG_FADDR1 = 8'h94;
  localparam logic [7:0] REG_FADDR2 = 8'h96;

  localparam logic [7:0] CODE_RESET = 8'd254;
  localparam logic [7:0] CODE_FLUSH = 8'd255;

  localparam logic OP_READ    = 1'b0;
  localparam logic OP_WRITE   = 1'b1;
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH,
    ST_FLUSH_END
  } state_t;

  typedef struct packed {
    logic capture;      // latch the incoming transaction
    logic exec;         // carry out the latched transaction
    logic flush_issue;  // read the next pixel of a flush
  } cmd_t;

  typedef struct packed {
    logic flush_req;    // latched transaction is a flush command
    logic last_issue;   // flush index points at the final counted pixel
  } status_t;

endpackage

### rtl/io_regs_pixel_and_flash_pointer.sv
// Top level of the pixel and flash pointer register block.
// Depends on iorpf_pkg, iorpf_ctrl and iorpf_dp.

// A bus access is taken when start is high and busy is low. A read gives one
// result, marked by strobe for one cycle; the block is busy while it carries
// out the access and can take the next access in the cycle the result shows.
// Writes give no result. A flush (control write of 255) streams the counted
// pixels as one word per cycle from the pixel store RAM read port, the final
// one marked by last; the block stays busy through the access, flush and
// flush-end states. The receiver cannot stall: each result is valid only in
// its strobe cycle. The pixel store needs no clearing pass after reset;
// unwritten pixels read as 0.
module io_regs_pixel_and_flash_pointer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [7:0]                    addr,
  input  logic [7:0]                    bus_data,
  output logic                          strobe,
  output logic                          kind,
  output logic [7:0]                    read_data,
  output logic                          flash_fetch,
  output logic [iorpf_pkg::PTR_W-1:0]   flash_addr,
  output logic [iorpf_pkg::PIXEL_W-1:0] pixel_word,
  output logic                          last
);

  iorpf_pkg::cmd_t    cmd;
  iorpf_pkg::status_t status;

  iorpf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  iorpf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .op         (op),
    .addr       (addr),
    .bus_data   (bus_data),
    .strobe     (strobe),
    .kind       (kind),
    .read_data  (read_data),
    .flash_fetch(flash_fetch),
    .flash_addr (flash_addr),
    .pixel_word (pixel_word),
    .last       (last)
  );

endmodule

### rtl/iorpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iorpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/iorpf_ctrl.sv
// Controller state machine for the pixel and flash pointer register block.
// Depends on iorpf_pkg and the assertion macro header.
`include "io_regs_pixel_and_flash_pointer_assert.svh"

module iorpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  iorpf_pkg::status_t status,
  output logic               busy,
  output iorpf_pkg::cmd_t    cmd
);

  iorpf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iorpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iorpf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = iorpf_pkg::ST_ACCESS;
        end
      end
      iorpf_pkg::ST_ACCESS: begin
        state_next = status.flush_req ? iorpf_pkg::ST_FLUSH : iorpf_pkg::ST_IDLE;
      end
      iorpf_pkg::ST_FLUSH: begin
        if (status.last_issue) begin
          state_next = iorpf_pkg::ST_FLUSH_END;
        end
      end
      iorpf_pkg::ST_FLUSH_END: begin
        state_next = iorpf_pkg::ST_IDLE;
      end
      default: begin
        state_next = iorpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = (state != iorpf_pkg::ST_IDLE);
    cmd.capture     = (state == iorpf_pkg::ST_IDLE) && start;
    cmd.exec        = (state == iorpf_pkg::ST_ACCESS);
    cmd.flush_issue = (state == iorpf_pkg::ST_FLUSH);
  end

  `IORPF_ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> state == iorpf_pkg::ST_IDLE)
  `IORPF_ASSERT(a_access_from_idle, clk, rst,
    $rose(busy) |-> $past(start) && state == iorpf_pkg::ST_ACCESS)
  `IORPF_ASSERT(a_flush_end_from_flush, clk, rst,
    state == iorpf_pkg::ST_FLUSH_END |-> $past(state) == iorpf_pkg::ST_FLUSH)

endmodule

### rtl/iorpf_dp.sv
// Datapath: pixel store, cursor, count, flash pointer and result registers.
// Depends on iorpf_pkg, iorpf_ram and the assertion macro header.
`include "io_regs_pixel_and_flash_pointer_assert.svh"

module iorpf_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  iorpf_pkg::cmd_t                   cmd,
  output iorpf_pkg::status_t                status,
  input  logic                              op,
  input  logic [7:0]                        addr,
  input  logic [7:0]                        bus_data,
  output logic                              strobe,
  output logic                              kind,
  output logic [7:0]                        read_data,
  output logic                              flash_fetch,
  output logic [iorpf_pkg::PTR_W-1:0]       flash_addr,
  output logic [iorpf_pkg::PIXEL_W-1:0]     pixel_word,
  output logic                              last
);

  // Latched transaction
  logic       op_q;
  logic [7:0] addr_q;
  logic [7:0] data_q;

  logic [iorpf_pkg::CURSOR_W-1:0] cursor;
  logic [iorpf_pkg::COUNT_W-1:0]  count;
  logic [iorpf_pkg::PTR_W-1:0]    pointer;
  logic [iorpf_pkg::CURSOR_W-1:0] idx;
  logic [iorpf_pkg::PIXEL_SLOTS-1:0] valid;
  logic                           vld_q;
  logic                           issue_d;
  logic                           last_d;

  logic                           ram_we;
  logic [iorpf_pkg::PIXEL_W-1:0]  ram_wdata;
  logic [iorpf_pkg::CURSOR_W-1:0] ram_raddr;
  logic [iorpf_pkg::PIXEL_W-1:0]  ram_rdata;
  logic [iorpf_pkg::PIXEL_W-1:0]  px;

  logic [iorpf_pkg::CURSOR_W-1:0] cursor_next;
  logic [iorpf_pkg::COUNT_W-1:0]  count_next;
  logic [iorpf_pkg::PTR_W-1:0]    pointer_next;
  logic [7:0]                     reply;
  logic                           is_read;

  iorpf_ram #(
    .WIDTH(iorpf_pkg::PIXEL_W),
    .DEPTH(iorpf_pkg::PIXEL_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cursor),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Walk the store during a flush, otherwise keep the current pixel ready.
  assign ram_raddr = cmd.flush_issue ? idx : cursor;
  // Entries never written read as zero.
  assign px        = vld_q ? ram_rdata : '0;
  assign is_read   = (op_q == iorpf_pkg::OP_READ);

  assign status.flush_req  = (op_q == iorpf_pkg::OP_WRITE) && (addr_q == iorpf_pkg::REG_CTRL)
                             && (data_q == iorpf_pkg::CODE_FLUSH);
  assign status.last_issue = ({1'b0, idx} == count - iorpf_pkg::COUNT_W'(1));

  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = px;
    cursor_next  = cursor;
    count_next   = count;
    pointer_next = pointer;
    reply        = '0;
    if (cmd.exec) begin
      if (!is_read) begin
        case (addr_q)
          iorpf_pkg::REG_CTRL: begin
            if (data_q == iorpf_pkg::CODE_RESET) begin
              count_next  = iorpf_pkg::COUNT_W'(1);
              cursor_next = '0;
            end else if (data_q < 8'(iorpf_pkg::PIXEL_SLOTS)) begin
              cursor_next = data_q[iorpf_pkg::CURSOR_W-1:0];
              if ({1'b0, data_q} >= 9'(count)) begin
                count_next = iorpf_pkg::COUNT_W'(data_q) + iorpf_pkg::COUNT_W'(1);
              end
            end
          end
          iorpf_pkg::REG_RED: begin
            ram_we    = 1'b1;
            ram_wdata = {px[23:16], data_q, px[7:0]};
          end
          iorpf_pkg::REG_GREEN: begin
            ram_we    = 1'b1;
            ram_wdata = {data_q, px[15:0]};
          end
          iorpf_pkg::REG_BLUE: begin
            ram_we    = 1'b1;
            ram_wdata = {px[23:8], data_q};
          end
          iorpf_pkg::REG_FADDR0: pointer_next = {pointer[19:8], data_q};
          iorpf_pkg::REG_FADDR1: pointer_next = {pointer[19:16], data_q, pointer[7:0]};
          iorpf_pkg::REG_FADDR2: pointer_next = {data_q[3:0], pointer[15:0]};
          default: ;
        endcase
      end else begin
        case (addr_q)
          iorpf_pkg::REG_CTRL:   reply = 8'(cursor);
          iorpf_pkg::REG_RED:    reply = px[15:8];
          iorpf_pkg::REG_GREEN:  reply = px[23:16];
          iorpf_pkg::REG_BLUE:   reply = px[7:0];
          iorpf_pkg::REG_FADDR0: reply = pointer[7:0];
          iorpf_pkg::REG_FADDR1: reply = pointer[15:8];
          iorpf_pkg::REG_FADDR2: reply = {4'b0, pointer[19:16]};
          // Advance the pointer past the fetched byte; wraps at 20 bits.
          iorpf_pkg::REG_FDATA:  pointer_next = pointer + iorpf_pkg::PTR_W'(1);
          default:               reply = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      addr_q <= addr;
      data_q <= bus_data;
    end
    vld_q <= valid[ram_raddr];
    if (cmd.exec) begin
      idx <= '0;
    end else if (cmd.flush_issue) begin
      idx <= idx + iorpf_pkg::CURSOR_W'(1);
    end
    last_d <= status.last_issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      cursor  <= '0;
      count   <= iorpf_pkg::COUNT_W'(1);
      pointer <= '0;
      issue_d <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      if (ram_we) begin
        valid[cursor] <= 1'b1;
      end
      cursor  <= cursor_next;
      count   <= count_next;
      pointer <= pointer_next;
      issue_d <= cmd.flush_issue;
      strobe  <= (cmd.exec && is_read) || issue_d;
    end
  end

  // Result registers; hold between transactions.
  always_ff @(posedge clk) begin
    if (cmd.exec && is_read) begin
      kind        <= iorpf_pkg::KIND_REPLY;
      read_data   <= reply;
      flash_fetch <= (addr_q == iorpf_pkg::REG_FDATA);
      flash_addr  <= (addr_q == iorpf_pkg::REG_FDATA) ? pointer : '0;
      pixel_word  <= '0;
      last        <= 1'b1;
    end else if (issue_d) begin
      kind        <= iorpf_pkg::KIND_PIXEL;
      read_data   <= '0;
      flash_fetch <= 1'b0;
      flash_addr  <= '0;
      pixel_word  <= px;
      last        <= last_d;
    end
  end

  `IORPF_ASSERT(a_reply_is_last, clk, rst,
    strobe && kind == iorpf_pkg::KIND_REPLY |-> last)
  `IORPF_ASSERT(a_pixel_clean, clk, rst,
    strobe && kind == iorpf_pkg::KIND_PIXEL |-> read_data == 8'd0 && !flash_fetch)
  `IORPF_ASSERT(a_count_range, clk, rst,
    count != '0 && count <= iorpf_pkg::COUNT_W'(iorpf_pkg::PIXEL_SLOTS))

endmodule

### tb/tb_io_regs_pixel_and_flash_pointer.sv
`timescale 1ns / 1ps
// Testbench for the pixel and flash pointer register block: a directed table, then random
// bus accesses, replies and pixel words checked against a behavioral model or typed rows.
// Depends on iorpf_pkg and io_regs_pixel_and_flash_pointer.
module tb_io_regs_pixel_and_flash_pointer;
  import iorpf_pkg::*;

  localparam logic [7:0] UNMAPPED_LOW  = 8'h00;
  localparam logic [7:0] UNMAPPED_MID  = 8'h7F;
  localparam logic [7:0] UNMAPPED_HIGH = 8'hFF;
  localparam logic [7:0] LAST_SLOT     = 8'(PIXEL_SLOTS - 1);
  localparam logic [7:0] FIRST_BAD     = 8'(PIXEL_SLOTS);
  localparam logic       TYPED         = 1'b1;
  localparam logic       MODELED       = 1'b0;
  localparam int         RANDOM_ITEMS  = 305;

  typedef struct packed {
    logic             kind;
    logic [7:0]       rd;
    logic             ff;
    logic [PTR_W-1:0] fa;
    logic [PIXEL_W-1:0] pw;
    logic             last;
  } bus_result_t;

  typedef struct packed {
    logic             wr;
    logic [7:0]       reg_addr;
    logic [7:0]       wdata;
    logic             typed;
    logic [7:0]       rd;
    logic             ff;
    logic [PTR_W-1:0] fa;
  } access_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_READ;
  logic [7:0] addr = '0;
  logic [7:0] bus_data = '0;
  logic busy, strobe, kind, flash_fetch, last;
  logic [7:0] read_data;
  logic [PTR_W-1:0] flash_addr;
  logic [PIXEL_W-1:0] pixel_word;

  // typed-in reply for the transaction currently offered
  logic row_typed = MODELED;
  logic [7:0] row_rd = '0;
  logic row_ff = 1'b0;
  logic [PTR_W-1:0] row_fa = '0;

  // model state
  logic [PIXEL_W-1:0]  pixel_mem [PIXEL_SLOTS];
  logic [CURSOR_W-1:0] cursor_m = '0;
  logic [COUNT_W-1:0]  count_m = COUNT_W'(1);
  logic [PTR_W-1:0]    fptr_m = '0;

  bus_result_t expected_words [$];
  int mismatches = 0;
  int burst_left = 0;

  localparam logic [7:0] COLOR_REGS [3] = '{REG_RED, REG_GREEN, REG_BLUE};
  localparam logic [7:0] PTR_REGS [3] = '{REG_FADDR0, REG_FADDR1, REG_FADDR2};
  localparam logic [7:0] READ_REGS [4] = '{REG_CTRL, REG_RED, REG_GREEN, REG_BLUE};

  access_row_t directed_rows [25] = '{
    '{OP_READ,  REG_CTRL,      8'h00,        TYPED,   8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_RED,       8'h00,        TYPED,   8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_FDATA,     8'h00,        TYPED,   8'h00, 1'b1, 20'h00000},
    '{OP_WRITE, REG_FADDR0,    8'hFF,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_FADDR1,    8'hFF,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_FADDR2,    8'hFF,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_FADDR2,    8'h00,        TYPED,   8'h0F, 1'b0, 20'h00000},
    '{OP_READ,  REG_FDATA,     8'h00,        TYPED,   8'h00, 1'b1, 20'hFFFFF},
    '{OP_READ,  REG_FDATA,     8'h00,        TYPED,   8'h00, 1'b1, 20'h00000},
    '{OP_WRITE, REG_CTRL,      LAST_SLOT,    MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_RED,       8'hFF,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_GREEN,     8'hA5,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_BLUE,      8'h5A,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_GREEN,     8'h00,        TYPED,   8'hA5, 1'b0, 20'h00000},
    '{OP_READ,  REG_CTRL,      8'h00,        TYPED,   LAST_SLOT, 1'b0, 20'h00000},
    '{OP_WRITE, REG_CTRL,      FIRST_BAD,    MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_CTRL,      8'h00,        TYPED,   LAST_SLOT, 1'b0, 20'h00000},
    '{OP_WRITE, REG_CTRL,      CODE_FLUSH,   MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_FDATA,     8'h12,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_READ,  UNMAPPED_LOW,  8'h00,        TYPED,   8'h00, 1'b0, 20'h00000},
    '{OP_READ,  UNMAPPED_HIGH, 8'hFF,        TYPED,   8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_CTRL,      CODE_RESET,   MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, REG_CTRL,      CODE_FLUSH,   MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_READ,  REG_FADDR0,    8'h00,        MODELED, 8'h00, 1'b0, 20'h00000},
    '{OP_WRITE, UNMAPPED_MID,  8'h00,        MODELED, 8'h00, 1'b0, 20'h00000}
  };

  io_regs_pixel_and_flash_pointer DUT (.*);

  always #5 clk = ~clk;

  // Work out the replies and pixel words one accepted transaction causes.
  task automatic compute_bus_outputs(input logic wr, input logic [7:0] a, input logic [7:0] d);
    logic [PIXEL_W-1:0] px;
    logic [7:0] rd;
    px = pixel_mem[cursor_m];
    rd = '0;
    if (wr) begin
      case (a)
        REG_CTRL: begin
          if (d == CODE_RESET) begin
            count_m = COUNT_W'(1);
            cursor_m = '0;
          end else if (d == CODE_FLUSH) begin
            for (int i = 0; i < count_m; i++)
              expected_words.push_back(bus_result_t'{KIND_PIXEL, 8'h00, 1'b0, '0,
                                                     pixel_mem[i], (i + 1 == count_m)});
          end else if (d < PIXEL_SLOTS) begin
            if (COUNT_W'(d) >= count_m) count_m = COUNT_W'(d) + COUNT_W'(1);
            cursor_m = CURSOR_W'(d);
          end
        end
        REG_RED:    pixel_mem[cursor_m] = {px[23:16], d, px[7:0]};
        REG_GREEN:  pixel_mem[cursor_m] = {d, px[15:0]};
        REG_BLUE:   pixel_mem[cursor_m] = {px[23:8], d};
        REG_FADDR0: fptr_m[7:0] = d;
        REG_FADDR1: fptr_m[15:8] = d;
        REG_FADDR2: fptr_m[19:16] = d[3:0];
        default: ;
      endcase
    end else if (a == REG_FDATA) begin
      expected_words.push_back(bus_result_t'{KIND_REPLY, 8'h00, 1'b1, fptr_m, '0, 1'b1});
      fptr_m = fptr_m + PTR_W'(1);
    end else begin
      case (a)
        REG_CTRL:   rd = 8'(cursor_m);
        REG_RED:    rd = px[15:8];
        REG_GREEN:  rd = px[23:16];
        REG_BLUE:   rd = px[7:0];
        REG_FADDR0: rd = fptr_m[7:0];
        REG_FADDR1: rd = fptr_m[15:8];
        REG_FADDR2: rd = {4'h0, fptr_m[19:16]};
        default: ;
      endcase
      expected_words.push_back(bus_result_t'{KIND_REPLY, rd, 1'b0, '0, '0, 1'b1});
    end
  endtask

  task automatic check_field(input string name, input logic [PIXEL_W-1:0] want,
                             input logic [PIXEL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_bus
    bus_result_t want;
    if (!rst && start && !busy) begin
      compute_bus_outputs(op, addr, bus_data);
      // replace the modeled reply with the one typed into the table
      if (row_typed) begin
        want = expected_words.pop_back();
        expected_words.push_back(bus_result_t'{KIND_REPLY, row_rd, row_ff, row_fa, '0, 1'b1});
      end
    end
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result: kind %0b read_data 0x%0h pixel_word 0x%0h",
               kind, read_data, pixel_word);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", PIXEL_W'(want.kind), PIXEL_W'(kind));
        check_field("read_data", PIXEL_W'(want.rd), PIXEL_W'(read_data));
        check_field("flash_fetch", PIXEL_W'(want.ff), PIXEL_W'(flash_fetch));
        check_field("flash_addr", PIXEL_W'(want.fa), PIXEL_W'(flash_addr));
        check_field("pixel_word", want.pw, pixel_word);
        check_field("last", PIXEL_W'(want.last), PIXEL_W'(last));
      end
    end
  end

  // Idle for a random gap, possibly none, between bursts of back-to-back transactions.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic issue_access(input access_row_t row);
    pace_sender();
    start <= 1'b1;
    op <= row.wr;
    addr <= row.reg_addr;
    bus_data <= row.wdata;
    row_typed <= row.typed;
    row_rd <= row.rd;
    row_ff <= row.ff;
    row_fa <= row.fa;
    do @(posedge clk); while (busy);
  endtask

  // Let the last transaction reach the model before looking at the queue.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic pick_access(output access_row_t row);
    int sel;
    row = '0;
    row.typed = MODELED;
    row.wdata = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      row.wr = OP_WRITE;
      row.reg_addr = REG_CTRL;
      // keep most pixel counts short so flushes stay brief
      row.wdata = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                             : 8'($urandom_range(0, PIXEL_SLOTS - 1));
    end else if (sel < 21) begin
      row.wr = OP_WRITE;
      row.reg_addr = REG_CTRL;
      row.wdata = CODE_RESET;
    end else if (sel < 26) begin
      row.wr = OP_WRITE;
      row.reg_addr = REG_CTRL;
      row.wdata = CODE_FLUSH;
    end else if (sel < 29) begin
      row.wr = OP_WRITE;
      row.reg_addr = REG_CTRL;
    end else if (sel < 49) begin
      row.wr = OP_WRITE;
      row.reg_addr = COLOR_REGS[$urandom_range(0, 2)];
    end else if (sel < 61) begin
      row.wr = OP_READ;
      row.reg_addr = READ_REGS[$urandom_range(0, 3)];
    end else if (sel < 71) begin
      row.wr = OP_WRITE;
      row.reg_addr = PTR_REGS[$urandom_range(0, 2)];
    end else if (sel < 77) begin
      row.wr = OP_READ;
      row.reg_addr = PTR_REGS[$urandom_range(0, 2)];
    end else if (sel < 89) begin
      row.wr = OP_READ;
      row.reg_addr = REG_FDATA;
    end else begin
      row.wr = 1'($urandom_range(0, 1));
      row.reg_addr = 8'($urandom_range(0, 255));
    end
  endtask

  initial begin : stimulus
    access_row_t row;
    for (int i = 0; i < PIXEL_SLOTS; i++) pixel_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) issue_access(directed_rows[i]);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_access(row);
      issue_access(row);
      if (n == RANDOM_ITEMS / 2) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
